>>> hw/rtl/i2c_masked_register_file_defines.svh
// Shared assertion macros for the masked register file checks.
`ifndef I2C_MASKED_REGISTER_FILE_DEFINES_SVH
`define I2C_MASKED_REGISTER_FILE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MRF_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MRF_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/i2cmrf_pkg.sv
package i2cmrf_pkg;

    localparam int REG_COUNT_DEF = 8;
    localparam int WORD_W        = 32;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 3;
    localparam int CFG_IDX_W     = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;
    localparam logic [BYTE_W-1:0] READ_LEN = 8'd4;

    // Fixed register roles
    localparam logic [BYTE_W-1:0] REG_VENDOR = 8'd0;
    localparam logic [BYTE_W-1:0] REG_DEVICE = 8'd1;
    localparam logic [BYTE_W-1:0] REG_LOCKED = 8'd5;

    typedef enum logic [1:0] {
        MODE_WRITE_BYTE = 2'd0,
        MODE_WRITE_STOP = 2'd1,
        MODE_READ_START = 2'd2,
        MODE_READ_BYTE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VENDOR_WORD   = 8'd0,
        CFG_DEVICE_WORD   = 8'd1,
        CFG_FLAG_READONLY = 8'd2,
        CFG_FLAG_RESERVED = 8'd3
    } cfg_index_t;

    typedef struct packed {
        mode_t             mode;
        logic [BYTE_W-1:0] bus_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              error;
    } out_item_t;

    typedef struct packed {
        logic readonly_write;
        logic reserved_write;
    } err_flags_t;

    // Commit request from the engine to the register file
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] index;
        logic [WORD_W-1:0] value;
    } rf_write_t;

    // Reserved bits per register (set bits are reserved)
    function automatic logic [WORD_W-1:0] reserved_mask(input logic [BYTE_W-1:0] index);
        logic [WORD_W-1:0] m;
        begin
            unique case (index)
                8'd0:    m = 32'h0000_0000;
                8'd1:    m = 32'h0000_0000;
                8'd4:    m = 32'hc020_1000;
                8'd5:    m = 32'hffff_dfff;
                8'd7:    m = 32'h0800_7f00;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

endpackage

>>> hw/rtl/i2c_masked_register_file.sv
// Byte-level I2C target in front of eight 32-bit registers. Each bus event
// (write byte, write stop, read start, read byte) is one input beat and gives
// exactly one result beat. A beat passes an input register, then the decode and
// mask logic, then a result register, and one beat per cycle is sustained while
// out_ready stays high. Registers 0 and 1 load from the configuration port;
// writes honor the per-register reserved masks. The configuration port is
// always ready and must only be used while no beats are in flight.
module i2c_masked_register_file
    import i2cmrf_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0]            rd_word;
    logic [$clog2(REG_COUNT)-1:0] rd_idx;
    err_flags_t                   flags;
    rf_write_t                    wr;

    assign cfg_ready = 1'b1;

    i2cmrf_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr),
        .rd_idx    (rd_idx),
        .rd_word   (rd_word),
        .flags     (flags)
    );

    i2cmrf_engine #(
        .REG_COUNT (REG_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .rd_word   (rd_word),
        .flags     (flags),
        .rd_idx    (rd_idx),
        .wr        (wr)
    );

endmodule

>>> hw/rtl/i2cmrf_regfile.sv
module i2cmrf_regfile
    import i2cmrf_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [WORD_W-1:0]             cfg_data,
    input  rf_write_t                     wr,
    input  logic [$clog2(REG_COUNT)-1:0]  rd_idx,
    output logic [WORD_W-1:0]             rd_word,
    output err_flags_t                    flags
);

    localparam int IDX_W = $clog2(REG_COUNT);

    logic [WORD_W-1:0] file_reg [REG_COUNT];
    err_flags_t        flags_reg;

    // Load identification words and error flags from config, commit masked writes otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                file_reg[i] <= '0;
            end
            flags_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_VENDOR_WORD:   file_reg[REG_VENDOR[IDX_W-1:0]] <= cfg_data;
                CFG_DEVICE_WORD:   file_reg[REG_DEVICE[IDX_W-1:0]] <= cfg_data;
                CFG_FLAG_READONLY: flags_reg.readonly_write <= cfg_data[0];
                CFG_FLAG_RESERVED: flags_reg.reserved_write <= cfg_data[0];
                default: ;
            endcase
        end
        else if (wr.en)
        begin
            file_reg[wr.index[IDX_W-1:0]] <= wr.value;
        end
    end

    assign rd_word = file_reg[rd_idx];
    assign flags   = flags_reg;

endmodule

>>> hw/rtl/i2cmrf_engine.sv
module i2cmrf_engine
    import i2cmrf_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  in_item_t                      in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output out_item_t                     out_item,
    input  logic [WORD_W-1:0]             rd_word,
    input  err_flags_t                    flags,
    output logic [$clog2(REG_COUNT)-1:0]  rd_idx,
    output rf_write_t                     wr
);

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam logic [BYTE_W-1:0] REG_LIMIT = BYTE_W'(REG_COUNT);

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic [BYTE_W-1:0] sel_reg, sel_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] data_reg, data_next;
    out_item_t         result;
    logic              advance;
    logic [CNT_W-1:0]  count_bump;
    logic [WORD_W-1:0] mask;
    logic              read_only;
    logic              out_of_range;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Hold the accepted beat in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    assign rd_idx       = sel_reg[IDX_W-1:0];
    assign mask         = reserved_mask(sel_reg);
    assign out_of_range = (sel_reg >= REG_LIMIT);
    assign read_only    = (sel_reg <= REG_DEVICE) || out_of_range || (sel_reg == REG_LOCKED);
    assign count_bump   = (count_reg == CNT_MAX) ? count_reg : count_reg + 3'd1;

    // Decode one bus event against the message state
    always_comb
    begin
        sel_next   = sel_reg;
        count_next = count_reg;
        data_next  = data_reg;
        result     = '0;
        wr         = '0;
        wr.index   = sel_reg;
        wr.value   = (data_reg & ~mask) | (rd_word & mask);
        unique case (s1_item_reg.mode)
            MODE_WRITE_BYTE:
            begin
                unique case (count_reg)
                    3'd0:    sel_next  = s1_item_reg.bus_byte;
                    3'd1:    data_next = '0;
                    3'd2:    data_next = data_reg | {24'd0, s1_item_reg.bus_byte};
                    3'd3:    data_next = data_reg | {16'd0, s1_item_reg.bus_byte, 8'd0};
                    3'd4:    data_next = data_reg | {8'd0, s1_item_reg.bus_byte, 16'd0};
                    3'd5:    data_next = data_reg | {s1_item_reg.bus_byte, 24'd0};
                    default: ;
                endcase
                count_next = count_bump;
            end
            MODE_WRITE_STOP:
            begin
                // Drop short, read-only and flagged reserved writes
                if (count_reg >= 3'd2)
                begin
                    if (read_only)
                    begin
                        result.error = flags.readonly_write;
                    end
                    else if (flags.reserved_write && ((data_reg & mask) != '0))
                    begin
                        result.error = 1'b1;
                    end
                    else
                    begin
                        wr.en = advance;
                    end
                end
                count_next = '0;
            end
            MODE_READ_START:
            begin
                if (out_of_range)
                begin
                    result.error = 1'b1;
                end
                else
                begin
                    data_next = rd_word;
                end
                count_next = '0;
            end
            MODE_READ_BYTE:
            begin
                if (count_reg == '0)
                begin
                    result.read_data = READ_LEN;
                end
                else
                begin
                    result.read_data = data_reg[BYTE_W-1:0];
                    data_next        = {8'd0, data_reg[WORD_W-1:BYTE_W]};
                end
                count_next = count_bump;
            end
        endcase
    end

    // Advance message state as each beat completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            count_reg <= '0;
            data_reg  <= '0;
        end
        else if (advance)
        begin
            sel_reg   <= sel_next;
            count_reg <= count_next;
            data_reg  <= data_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> hw/rtl/i2cmrf_checker.sv
`include "i2c_masked_register_file_defines.svh"

module i2cmrf_checker
    import i2cmrf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input in_item_t             in_item,
    input logic                 out_valid,
    input logic                 out_ready,
    input out_item_t            out_item,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [WORD_W-1:0]    cfg_data
);

    // No result may be shown while reset is held
    `MRF_ASSERT_ANY(a_reset_quiet, (!rst_n |-> !out_valid), "result valid during reset")

    // A stalled result beat keeps its payload
    `MRF_ASSERT_CLK(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_item)), "stalled result changed")

    // Only read bytes return data and never report an error, so no result carries both
    `MRF_ASSERT_CLK(a_err_no_data, (out_valid |-> !(out_item.error && (out_item.read_data != '0))), "error with read data")

    // With the result register empty the input side must take a beat
    `MRF_ASSERT_CLK(a_in_open, (!out_valid |-> in_ready), "input stalled with empty result")

    // Configuration writes are never back-pressured
    `MRF_ASSERT_CLK(a_cfg_open, (cfg_valid |-> cfg_ready), "configuration write stalled")

endmodule

bind i2c_masked_register_file i2cmrf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
